[src/anp_pkg.sv]
`default_nettype none

package anp_pkg;

    localparam logic [31:0] DEC_LIMIT = 32'd429496729;
    localparam logic [31:0] HEX_LIMIT = 32'h0FFF_FFFF;
    localparam logic [31:0] DEC_BASE  = 32'd10;
    localparam logic [3:0]  DEC_LAST_SAFE_DIGIT = 4'd5;

    // ASCII codes
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_LO_X  = 8'h78;
    localparam logic [7:0] CHAR_UP_X  = 8'h58;
    localparam logic [7:0] LO_HEX_BIAS = 8'h57; // 'a' - 10
    localparam logic [7:0] UP_HEX_BIAS = 8'h37; // 'A' - 10

    // character position within a field, saturating
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_LATER  = 2'd2;

    typedef struct packed {
        logic       is_dec;
        logic       is_hex;
        logic       is_zero;
        logic       is_x;
        logic [3:0] digit;
    } t_char_class;

    typedef struct packed {
        logic [31:0] value;
        logic        ok;
        logic        was_hex;
    } t_result;

endpackage

`default_nettype wire

[src/anp_char_if.sv]
`default_nettype none

interface anp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

[src/anp_result_if.sv]
`default_nettype none

interface anp_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        ok;
    logic        was_hex;

    modport source (output valid, output value, output ok, output was_hex, input ready);
    modport sink   (input valid, input value, input ok, input was_hex, output ready);
endinterface

`default_nettype wire

[src/anp_char_decode.sv]
`default_nettype none

module anp_char_decode
    import anp_pkg::*;
(
    input  wire logic [7:0] i_char,
    output t_char_class     o_class
);

    logic is_num;
    logic is_lo;
    logic is_up;
    logic [7:0] bias;
    logic [7:0] diff;

    always_comb begin
        is_num = (i_char >= CHAR_0) && (i_char <= CHAR_9);
        is_lo  = (i_char >= CHAR_LO_A) && (i_char <= CHAR_LO_F);
        is_up  = (i_char >= CHAR_UP_A) && (i_char <= CHAR_UP_F);
        if (is_lo) begin
            bias = LO_HEX_BIAS;
        end else if (is_up) begin
            bias = UP_HEX_BIAS;
        end else begin
            bias = CHAR_0;
        end
        diff = i_char - bias;

        o_class.is_dec  = is_num;
        o_class.is_hex  = is_num || is_lo || is_up;
        o_class.is_zero = (i_char == CHAR_0);
        o_class.is_x    = (i_char == CHAR_LO_X) || (i_char == CHAR_UP_X);
        o_class.digit   = diff[3:0];
    end

endmodule

`default_nettype wire

[src/anp_parse_core.sv]
`default_nettype none

module anp_parse_core
    import anp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_step,
    input  wire logic  i_last,
    input  wire t_char_class i_class,
    output t_result    o_result
);

    logic [31:0] r_acc,   n_acc;
    logic [1:0]  r_pos,   n_pos;
    logic        r_fwz,   n_fwz;
    logic        r_hex,   n_hex;
    logic        r_failed, n_failed;

    logic [31:0] digit_ext;
    logic [31:0] dec_acc;
    logic [31:0] hex_acc;
    logic        dec_bad;
    logic        hex_bad;

    always_comb begin
        digit_ext = {28'd0, i_class.digit};
        dec_acc   = r_acc * DEC_BASE + digit_ext;
        hex_acc   = {r_acc[27:0], 4'd0} + digit_ext;
        dec_bad   = !i_class.is_dec || (r_acc > DEC_LIMIT) ||
                    ((r_acc == DEC_LIMIT) && (i_class.digit > DEC_LAST_SAFE_DIGIT));
        hex_bad   = (r_acc > HEX_LIMIT) || !i_class.is_hex;

        n_acc    = r_acc;
        n_fwz    = r_fwz;
        n_hex    = r_hex;
        n_failed = r_failed;

        if (!r_failed) begin
            if (r_pos == POS_FIRST) begin
                n_fwz = i_class.is_zero;
                if (dec_bad) n_failed = 1'b1;
                else         n_acc    = dec_acc;
            end else if ((r_pos == POS_SECOND) && r_fwz && i_class.is_x) begin
                // bare "0x" is a bad decimal field
                if (i_last) begin
                    n_failed = 1'b1;
                end else begin
                    n_hex = 1'b1;
                    n_acc = '0;
                end
            end else if (r_hex) begin
                if (hex_bad) n_failed = 1'b1;
                else         n_acc    = hex_acc;
            end else begin
                if (dec_bad) n_failed = 1'b1;
                else         n_acc    = dec_acc;
            end
        end

        n_pos = (r_pos == POS_LATER) ? POS_LATER : r_pos + 2'd1;

        o_result.value   = n_failed ? '0 : n_acc;
        o_result.ok      = !n_failed;
        o_result.was_hex = n_hex;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_pos    <= POS_FIRST;
            r_fwz    <= 1'b0;
            r_hex    <= 1'b0;
            r_failed <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_acc    <= '0;
                r_pos    <= POS_FIRST;
                r_fwz    <= 1'b0;
                r_hex    <= 1'b0;
                r_failed <= 1'b0;
            end else begin
                r_acc    <= n_acc;
                r_pos    <= n_pos;
                r_fwz    <= n_fwz;
                r_hex    <= n_hex;
                r_failed <= n_failed;
            end
        end
    end

    a_field_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last) |=> (r_pos == POS_FIRST) && !r_failed && !r_hex && (r_acc == '0))
        else $error("field state not cleared after last character");

    a_hex_needs_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hex |-> r_fwz && (r_pos != POS_FIRST))
        else $error("hex mode without 0x prefix");

endmodule

`default_nettype wire

[src/ascii_number_parser.sv]
`default_nettype none

// ASCII number parser. Characters of one numeric field arrive one per request on
// i_char, the final one flagged by last_char. A field starting "0x"/"0X" with at
// least one more character is read as hex, anything else as decimal; a bad
// character or a value past 32 bits fails the field (ok = 0, value = 0), and
// the failure sticks until the last character. Exactly one result request is
// produced per field, on its last character; earlier characters produce none.
// Throughput is one character per clock unless a final character waits on a
// stalled result; the multiply-by-ten (or shift-by-four) add and its overflow
// compare in the parse core are combinational. An accepted character sits in an
// input register until it steps the core; a final one's result is then held in
// the result register on o_result. The result register takes the next result
// in the same cycle the current one is taken; while a result is stalled,
// non-final characters keep streaming in and only a final one waits.

module ascii_number_parser
    import anp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    anp_char_if.sink    i_char,
    anp_result_if.source o_result
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;

    // result register
    logic       r_out_valid;
    t_result    r_out;

    t_char_class char_class;
    t_result     core_result;
    logic        out_free;
    logic        step;

    anp_char_decode u_decode (
        .i_char  (r_in_char),
        .o_class (char_class)
    );

    anp_parse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_last   (r_in_last),
        .i_class  (char_class),
        .o_result (core_result)
    );

    // only a final character needs room in the result register
    assign out_free     = !r_out_valid || o_result.ready;
    assign step         = r_in_valid && (!r_in_last || out_free);
    assign i_char.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_char.ready) begin
                r_in_valid <= i_char.valid;
            end
            if (step && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_char <= i_char.char_code;
            r_in_last <= i_char.last_char;
        end
        if (step && r_in_last) begin
            r_out <= core_result;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.value   = r_out.value;
    assign o_result.ok      = r_out.ok;
    assign o_result.was_hex = r_out.was_hex;

    a_final_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in_last) |-> out_free)
        else $error("final character stepped into a full result register");

    a_held_char_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step) |=> r_in_valid && $stable(r_in_char) && $stable(r_in_last))
        else $error("held character lost or overwritten");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.ok) |-> (r_out.value == '0))
        else $error("failed field with nonzero value");

endmodule

`default_nettype wire

[verif/ascii_number_parser_test.sv]
`default_nettype none

// Block-level test of the ASCII number parser.
// Numeric fields are streamed in one character per request. A scoreboard class
// mirrors the parser state, predicts one result per field (on the character
// flagged last), and compares every result request against the oldest
// prediction. A short directed run comes first, then random fields that are
// mostly well formed (decimal, hex, values at the overflow edges) with broken
// fields and raw byte noise mixed in. Both ends idle at random, and once the
// result side holds off long enough to back the parser up into its input.

module ascii_number_parser_test;
    import anp_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 10;
    localparam int ITEM_TARGET  = 900;
    localparam int LONG_HOLD    = 300;  // receiver hold-off, long enough to fill the block
    localparam int QUIET_LIMIT  = 2000; // cycles with no request taken on either side
    localparam int DRAIN_CYCLES = 20;   // result lags its last character by the input and result registers

    // ------------------------------------------------------------------
    // Predicted parser state and the queue of results still owed
    // ------------------------------------------------------------------
    class parsed_value_board;
        logic [31:0] acc;
        logic [1:0]  pos;
        logic        lead_zero;
        logic        hex_mode;
        logic        bad;
        t_result     awaited[$];
        int unsigned mismatch_count;

        function new();
            restart_field();
            mismatch_count = 0;
        endfunction

        function void restart_field();
            acc       = '0;
            pos       = POS_FIRST;
            lead_zero = 1'b0;
            hex_mode  = 1'b0;
            bad       = 1'b0;
        endfunction

        // one decimal digit; the limit test runs before the multiply
        function void take_dec(logic [7:0] c);
            logic [7:0] offs;
            offs = c - CHAR_0;
            if (c < CHAR_0 || c > CHAR_9) begin
                bad = 1'b1;
            end else if (acc > DEC_LIMIT ||
                         (acc == DEC_LIMIT && offs[3:0] > DEC_LAST_SAFE_DIGIT)) begin
                bad = 1'b1;
            end else begin
                acc = acc * DEC_BASE + {28'd0, offs[3:0]};
            end
        endfunction

        function void take_char(logic [7:0] c, logic last);
            t_result    r;
            logic [7:0] offs;
            if (!bad) begin
                if (pos == POS_FIRST) begin
                    lead_zero = (c == CHAR_0);
                    take_dec(c);
                end else if (pos == POS_SECOND && lead_zero &&
                             (c == CHAR_LO_X || c == CHAR_UP_X)) begin
                    // a bare "0x" stays decimal and fails on the x
                    if (last) begin
                        bad = 1'b1;
                    end else begin
                        hex_mode = 1'b1;
                        acc      = '0;
                    end
                end else if (hex_mode) begin
                    // hex overflow is judged on the accumulator before the digit
                    if (acc > HEX_LIMIT) begin
                        bad = 1'b1;
                    end else if (c >= CHAR_0 && c <= CHAR_9) begin
                        offs = c - CHAR_0;
                        acc  = {acc[27:0], offs[3:0]};
                    end else if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
                        offs = c - LO_HEX_BIAS;
                        acc  = {acc[27:0], offs[3:0]};
                    end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
                        offs = c - UP_HEX_BIAS;
                        acc  = {acc[27:0], offs[3:0]};
                    end else begin
                        bad = 1'b1;
                    end
                end else begin
                    take_dec(c);
                end
            end
            if (pos != POS_LATER) pos = pos + 2'd1;
            if (last) begin
                r.value   = bad ? 32'd0 : acc;
                r.ok      = !bad;
                r.was_hex = hex_mode;
                awaited.push_back(r);
                restart_field();
            end
        endfunction

        function void check_result(logic [31:0] value, logic ok, logic was_hex);
            t_result exp_r;
            if (awaited.size() == 0) begin
                $error("result with no field pending: value %h ok %b was_hex %b",
                       value, ok, was_hex);
                mismatch_count++;
            end else begin
                exp_r = awaited.pop_front();
                if (value !== exp_r.value) begin
                    $error("value: expected %h, actual %h", exp_r.value, value);
                    mismatch_count++;
                end
                if (ok !== exp_r.ok) begin
                    $error("ok: expected %b, actual %b", exp_r.ok, ok);
                    mismatch_count++;
                end
                if (was_hex !== exp_r.was_hex) begin
                    $error("was_hex: expected %b, actual %b", exp_r.was_hex, was_hex);
                    mismatch_count++;
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels, block
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    anp_char_if   char_ch ();
    anp_result_if result_ch ();

    ascii_number_parser i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (char_ch),
        .o_result (result_ch)
    );

    parsed_value_board board;

    int unsigned sent_count;
    int unsigned quiet_cycles;
    bit          sender_burst;   // set: sender offers back to back
    bit          receiver_burst; // set: receiver always ready
    bit          hold_request;   // one-shot request for the long receiver hold-off
    bit          pressure_done;
    logic [7:0]  field_text[$];

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap(bit burst);
        int unsigned r;
        r = $urandom_range(99);
        if (burst || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // ------------------------------------------------------------------
    // Field construction
    // ------------------------------------------------------------------
    function automatic logic [7:0] hex_char(logic [3:0] d);
        if (d < 4'd10) return CHAR_0 + {4'd0, d};
        return ($urandom_range(1) ? CHAR_UP_A : CHAR_LO_A) + {4'd0, d} - 8'd10;
    endfunction

    function automatic void push_dec(logic [31:0] v);
        logic [7:0] digits[$];
        logic [31:0] rem;
        rem = v;
        do begin
            digits.push_front(CHAR_0 + 8'(rem % 10));
            rem = rem / 10;
        end while (rem != 0);
        foreach (digits[i]) field_text.push_back(digits[i]);
    endfunction

    function automatic void push_hex(logic [31:0] v, int n);
        for (int i = n - 1; i >= 0; i--) field_text.push_back(hex_char(v[4*i +: 4]));
    endfunction

    function automatic void push_zeros(int n);
        repeat (n) field_text.push_back(CHAR_0);
    endfunction

    function automatic void push_prefix();
        field_text.push_back(CHAR_0);
        field_text.push_back($urandom_range(1) ? CHAR_UP_X : CHAR_LO_X);
    endfunction

    function automatic logic [7:0] any_x();
        return $urandom_range(1) ? CHAR_UP_X : CHAR_LO_X;
    endfunction

    function automatic void make_field();
        int unsigned r;
        int unsigned idx;
        r = $urandom_range(99);
        if (r < 20) begin
            // plain decimal over the whole range, sometimes zero padded
            if ($urandom_range(3) == 0) push_zeros($urandom_range(1, 15));
            push_dec($urandom >> $urandom_range(31));
        end else if (r < 30) begin
            // random digit strings, the long ones overflow
            repeat ($urandom_range(1, 12)) field_text.push_back(CHAR_0 + 8'($urandom_range(9)));
        end else if (r < 40) begin
            // around the decimal overflow edge
            case ($urandom_range(2))
                0: begin
                    push_dec(DEC_LIMIT);
                    field_text.push_back(CHAR_0 + 8'($urandom_range(9)));
                end
                1: push_dec(32'hFFFF_FFFF - $urandom_range(7));
                default: begin
                    push_dec(DEC_LIMIT + $urandom_range(1));
                    field_text.push_back(CHAR_0 + 8'($urandom_range(9)));
                    if ($urandom_range(1)) field_text.push_back(CHAR_0 + 8'($urandom_range(9)));
                end
            endcase
        end else if (r < 60) begin
            push_prefix();
            if ($urandom_range(3) == 0) push_zeros($urandom_range(1, 4));
            push_hex($urandom, $urandom_range(1, 8));
        end else if (r < 68) begin
            // around the hex overflow edge
            push_prefix();
            if ($urandom_range(1)) push_hex(HEX_LIMIT + $urandom_range(1), 8);
            else push_hex($urandom, 8);
            repeat ($urandom_range(0, 2)) field_text.push_back(hex_char($urandom_range(15)));
        end else if (r < 78) begin
            // well-formed field with one character spoiled
            if ($urandom_range(1)) begin
                push_dec($urandom);
            end else begin
                push_prefix();
                push_hex($urandom, $urandom_range(1, 8));
            end
            idx = $urandom_range(field_text.size() - 1);
            field_text[idx] = 8'($urandom_range(255));
            repeat ($urandom_range(0, 3)) field_text.push_back(hex_char($urandom_range(15)));
        end else if (r < 86) begin
            // x in and out of the prefix slot
            case ($urandom_range(3))
                0: push_prefix();
                1: begin
                    push_prefix();
                    field_text.push_back(8'($urandom_range(255)));
                end
                2: begin
                    push_dec($urandom_range(99));
                    field_text.push_back(any_x());
                    push_hex($urandom_range(255), 2);
                end
                default: begin
                    field_text.push_back(any_x());
                    push_dec($urandom_range(999));
                end
            endcase
        end else begin
            repeat ($urandom_range(1, 6)) field_text.push_back(8'($urandom_range(255)));
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: drives at the falling edge, sees the handshake at the rising one
    // ------------------------------------------------------------------
    task automatic send_char(logic [7:0] c, logic last);
        int unsigned gap;
        gap = pick_gap(sender_burst);
        if (gap != 0) begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= c;
        char_ch.last_char <= last;
        @(posedge i_clk);
        while (!char_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic send_field();
        foreach (field_text[i]) send_char(field_text[i], i == field_text.size() - 1);
        field_text.delete();
    endtask

    task automatic send_text(string s);
        foreach (s[i]) field_text.push_back(s[i]);
        send_field();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int unsigned gap;
        bit          hold_done;
        hold_done = 1'b0;
        result_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else begin
                gap = pick_gap(receiver_burst);
                if (gap != 0) begin
                    result_ch.ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                result_ch.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every taken request on either side goes to the board
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_ch.valid && result_ch.ready)
                board.check_result(result_ch.value, result_ch.ok, result_ch.was_hex);
            if (char_ch.valid && char_ch.ready)
                board.take_char(char_ch.char_code, char_ch.last_char);
        end
    end

    // Watchdog: too long with nothing moving on either channel ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (char_ch.valid && char_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("ascii_number_parser verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        board             = new();
        i_rst_n           = 1'b0;
        char_ch.valid     = 1'b0;
        char_ch.char_code = 8'd0;
        char_ch.last_char = 1'b0;
        sent_count        = 0;
        sender_burst      = 1'b0;
        receiver_burst    = 1'b0;
        hold_request      = 1'b0;
        pressure_done     = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: all-ones byte as a lone character, bare upper-case prefix,
        // mixed-case hex, largest decimal, non-digit just above '9', zero pad
        field_text.push_back(8'hFF);
        send_field();
        send_text("0X");
        send_text("0xfA");
        send_text("4294967295");
        send_text("1:");
        send_text("00");

        while (sent_count < ITEM_TARGET) begin
            if ($urandom_range(29) == 0) sender_burst = ~sender_burst;
            if ($urandom_range(29) == 0) receiver_burst = ~receiver_burst;
            // back the block up: result side stalls, characters keep coming
            if (!pressure_done && sent_count >= 400) begin
                pressure_done = 1'b1;
                sender_burst  = 1'b1;
                hold_request  = 1'b1;
            end
            make_field();
            send_field();
        end
        char_ch.valid <= 1'b0;

        while (board.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatch_count == 0)
            $display("ascii_number_parser verification clean");
        else
            $display("ascii_number_parser verification failed");
        $finish;
    end

endmodule

`default_nettype wire
